/* rtl/nsr_pkg.sv */
// Shared types and constants for the Newton square root block.
// Holds the controller state encoding and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

	localparam int VALUE_W = 32;
	localparam int ROOT_W  = 24;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DIV    = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic update;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic div_last;
		logic converged;
	} status_t;

endpackage

`default_nettype wire

/* rtl/nsr_datapath.sv */
// Datapath for the Newton square root: radicand, guess, serial restoring
// divider, guess update, convergence test and output register.
// Depends on nsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsr_datapath #(
	parameter int FRAC_BITS = 16,
	parameter int EPSILON   = 1
) (
	input  wire                              clk,
	input  wire  [nsr_pkg::VALUE_W-1:0]      value,
	input  wire  nsr_pkg::cmd_t              cmd,
	output nsr_pkg::status_t                 stat,
	output logic [nsr_pkg::ROOT_W-1:0]       root,
	output logic                             invalid
);

	localparam int SW = nsr_pkg::VALUE_W - 1 + FRAC_BITS;
	localparam int CW = $clog2(SW);

	logic [SW-1:0] scaled_q;
	logic [SW-1:0] guess_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;

	logic [SW:0]   rem_shift;
	logic [SW:0]   trial;
	logic [SW:0]   sum;
	logic [SW-1:0] new_guess;
	logic [SW-1:0] diff;
	logic [SW-1:0] load_guess;
	logic [SW-1:0] load_scaled;
	logic          value_neg;
	logic          value_zero;

	assign value_neg   = value[nsr_pkg::VALUE_W-1];
	assign value_zero  = (value == '0);
	assign load_scaled = SW'(value[nsr_pkg::VALUE_W-2:0]) << FRAC_BITS;
	assign load_guess  = value_neg ? '0 : SW'(value[nsr_pkg::VALUE_W-2:0]);

	assign rem_shift = {rem_q, quo_q[SW-1]};
	assign trial     = rem_shift - {1'b0, guess_q};

	assign sum       = {1'b0, guess_q} + {1'b0, quo_q};
	assign new_guess = sum[SW:1];
	assign diff      = (new_guess > guess_q) ? (new_guess - guess_q) : (guess_q - new_guess);

	assign stat.special   = value_neg | value_zero;
	assign stat.div_last  = (cnt_q == '0);
	assign stat.converged = (diff <= SW'(EPSILON)) | (new_guess == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q    <= value_neg;
			scaled_q <= load_scaled;
			guess_q  <= load_guess;
			quo_q    <= load_scaled;
			rem_q    <= '0;
			cnt_q    <= CW'(SW - 1);
		end else if (cmd.update) begin
			guess_q <= new_guess;
			quo_q   <= scaled_q;
			rem_q   <= '0;
			cnt_q   <= CW'(SW - 1);
		end else if (cmd.step) begin
			if (!trial[SW]) begin
				rem_q <= trial[SW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[SW-1:0];
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			invalid <= neg_q;
			if (guess_q > SW'({nsr_pkg::ROOT_W{1'b1}})) begin
				root <= '1;
			end else begin
				root <= guess_q[nsr_pkg::ROOT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/nsr_ctrl.sv */
// Controller for the Newton square root: sequences load, division,
// guess update and result transfer; counts Newton steps.
// Depends on nsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsr_ctrl #(
	parameter int MAX_ITERATIONS = 40
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire                   out_stall,
	input  wire nsr_pkg::status_t stat,
	output nsr_pkg::cmd_t         cmd
);

	localparam int IW = $clog2(MAX_ITERATIONS);

	nsr_pkg::state_t state_q;
	nsr_pkg::state_t state_d;
	logic [IW-1:0]   iter_q;
	logic            out_valid_q;
	logic            last_iter;

	assign in_stall  = (state_q != nsr_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign last_iter = (iter_q == IW'(MAX_ITERATIONS - 1));

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.update = 1'b0;
		cmd.emit   = 1'b0;
		unique case (state_q)
			nsr_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.special ? nsr_pkg::ST_FINISH : nsr_pkg::ST_DIV;
				end
			end
			nsr_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (stat.div_last) begin
					state_d = nsr_pkg::ST_UPDATE;
				end
			end
			nsr_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = (stat.converged || last_iter) ? nsr_pkg::ST_FINISH
				                                           : nsr_pkg::ST_DIV;
			end
			nsr_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d  = nsr_pkg::ST_IDLE;
				end
			end
			default: state_d = nsr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nsr_pkg::ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				iter_q <= '0;
			end else if (cmd.update) begin
				iter_q <= iter_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/newton_square_root.sv */
// Newton square root, signed Q16.16 radicand to unsigned Q8.16 root.
// One item at a time. Negative or zero radicand: goes straight to the finish state.
// Otherwise each Newton step runs the one-bit-per-cycle restoring divider over
// 31 + FRAC_BITS quotient bits, then updates the guess; up to MAX_ITERATIONS
// steps.
// Reset: asynchronous, active low; clears controller state and output valid.
`timescale 1ns / 1ps
`default_nettype none

module newton_square_root #(
	parameter int FRAC_BITS      = 16,
	parameter int EPSILON        = 1,
	parameter int MAX_ITERATIONS = 40
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [nsr_pkg::VALUE_W-1:0]      value,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [nsr_pkg::ROOT_W-1:0]       root,
	output logic                             invalid
);

	nsr_pkg::cmd_t    cmd;
	nsr_pkg::status_t stat;

	nsr_ctrl #(
		.MAX_ITERATIONS(MAX_ITERATIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	nsr_datapath #(
		.FRAC_BITS(FRAC_BITS),
		.EPSILON  (EPSILON)
	) u_datapath (
		.clk     (clk),
		.value   (value),
		.cmd     (cmd),
		.stat    (stat),
		.root    (root),
		.invalid (invalid)
	);

endmodule

`default_nettype wire
